FILE: hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned DefColumns = 64;
  localparam int unsigned DefRows    = 32;

  localparam int unsigned ReqW      = 3;
  localparam int unsigned CharW     = 8;
  localparam int unsigned TargetW   = 11;
  localparam int unsigned ReadColW  = 6;
  localparam int unsigned ReadRowW  = 5;
  localparam int unsigned CurColW   = 6;
  localparam int unsigned CurRowW   = 5;
  localparam int unsigned CellW     = 16;
  localparam int unsigned AttrW     = 8;

  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CellW-1:0] BlankCell = 16'h0220;
  localparam logic [AttrW-1:0] AttrReset = 8'h02;
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharCr    = 8'h0d;
  localparam logic [CharW-1:0] CharLf    = 8'h0a;

  typedef enum logic [ReqW-1:0] {
    REQ_PUT   = 3'd0,
    REQ_SET   = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_BACK  = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

endpackage

FILE: hdl/text_console_writer.sv
// Text console writer: character-cell screen store, cursor and scroll.
`timescale 1ns / 1ps

// The screen lives in one ROWS*COLUMNS x 16 memory with one write and one
// registered read port; rows are kept as a ring, so a scroll only moves the
// top-row pointer and blanks one row. A cell read waits for the memory
// read register, a put that scrolls writes one blank per column, and a
// clear writes one blank per cell. After reset a clearing pass over all
// cells runs before the first item is taken; text_attr may be written
// at any time. A result waiting in the output register holds off the
// next item until the result is taken.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::DefColumns,
  parameter int unsigned ROWS    = tcw_pkg::DefRows
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::AttrW-1:0]      cfg_wdata_i,   // text_attr
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // char_code[7:0], target_col[18:8], target_row[29:19],
  // read_col[35:30], read_row[40:36], zeros above
  input  logic [tcw_pkg::InDataW-1:0]    s_tdata_i,
  input  logic [tcw_pkg::ReqW-1:0]       s_tuser_i,     // req_type[2:0]
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // cursor_col[5:0], cursor_row[10:6], cell_data[26:11], scrolled[27],
  // zeros above
  output logic [tcw_pkg::OutDataW-1:0]   m_tdata_o
);
  import tcw_pkg::*;

  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned Depth = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(Depth);

  localparam logic [CW-1:0] LastCol = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow = RW'(ROWS - 1);
  localparam logic [RW:0]   RowsW   = (RW+1)'(ROWS);
  localparam logic [AW-1:0] ColsA   = AW'(COLUMNS);
  localparam logic [AW-1:0] LastA   = AW'(Depth - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_BLANK,
    ST_CLEAR
  } state_e;

  // input fields
  req_e                req;
  logic [CharW-1:0]    char_code;
  logic [TargetW-1:0]  target_col;
  logic [TargetW-1:0]  target_row;
  logic [ReadColW-1:0] read_col;
  logic [ReadRowW-1:0] read_row;

  assign req        = req_e'(s_tuser_i);
  assign char_code  = s_tdata_i[7:0];
  assign target_col = s_tdata_i[18:8];
  assign target_row = s_tdata_i[29:19];
  assign read_col   = s_tdata_i[35:30];
  assign read_row   = s_tdata_i[40:36];

  state_e            state_q;
  logic [CW-1:0]     cur_col_q, cur_col_d;
  logic [RW-1:0]     cur_row_q, cur_row_d;
  logic [RW-1:0]     top_q;
  logic [RW-1:0]     blank_row_q;
  logic [AW-1:0]     cnt_q;
  logic              clr_res_q;
  logic [AttrW-1:0]  attr_q;
  logic              rd_ok_q;

  logic              out_valid_q;
  logic [CurColW-1:0] out_col_q;
  logic [CurRowW-1:0] out_row_q;
  logic [CellW-1:0]  out_cell_q;
  logic              out_scr_q;

  // screen memory
  logic [CellW-1:0]  mem [Depth];
  logic [CellW-1:0]  rd_data_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CellW-1:0]  mem_wdata;
  logic [AW-1:0]     rd_addr;

  logic              accept;
  logic              is_nl;
  logic              is_null;
  logic              row_inc;
  logic              put_scroll;
  logic              put_write;
  logic [CellW-1:0]  put_cell;
  logic              rd_ok;
  logic [CW-1:0]     col_step;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= RowsW) s = s - RowsW;
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(AW'(r) * ColsA) + AW'(c);
  endfunction

  assign s_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_tready_i);
  assign accept     = s_tvalid_i && s_tready_o;

  assign is_nl    = (char_code == CharCr) || (char_code == CharLf);
  assign is_null  = (char_code == CharNul);
  assign put_cell = {attr_q, char_code};
  assign rd_ok    = (9'(read_col) < 9'(COLUMNS)) && (9'(read_row) < 9'(ROWS));

  always_comb begin
    row_inc    = 1'b0;
    col_step   = cur_col_q;
    put_scroll = 1'b0;
    put_write  = 1'b0;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    unique case (req)
      REQ_PUT: begin
        if (!is_null) begin
          if (is_nl) begin
            col_step = '0;
            row_inc  = 1'b1;
          end else begin
            put_write = 1'b1;
            if (cur_col_q == LastCol) begin
              col_step = '0;
              row_inc  = 1'b1;
            end else begin
              col_step = cur_col_q + 1'b1;
            end
          end
          put_scroll = row_inc && (cur_row_q == LastRow);
          cur_col_d  = col_step;
          if (row_inc && !put_scroll) cur_row_d = cur_row_q + 1'b1;
        end
      end
      REQ_SET: begin
        if (target_col[TargetW-1]) cur_col_d = '0;
        else if (target_col[TargetW-2:0] > (TargetW-1)'(COLUMNS - 1)) cur_col_d = LastCol;
        else cur_col_d = target_col[CW-1:0];
        if (target_row[TargetW-1]) cur_row_d = '0;
        else if (target_row[TargetW-2:0] > (TargetW-1)'(ROWS - 1)) cur_row_d = LastRow;
        else cur_row_d = target_row[RW-1:0];
      end
      REQ_CLEAR: begin
        cur_col_d = '0;
        cur_row_d = '0;
      end
      REQ_BACK: begin
        if (cur_col_q != '0) begin
          cur_col_d = cur_col_q - 1'b1;
        end else if (cur_row_q != '0) begin
          cur_col_d = LastCol;
          cur_row_d = cur_row_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(phys_row(cur_row_q, top_q), cur_col_q);
    mem_wdata = put_cell;
    unique case (state_q)
      ST_IDLE:  mem_we = accept && (req == REQ_PUT) && put_write;
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(blank_row_q, cnt_q[CW-1:0]);
        mem_wdata = BlankCell;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = BlankCell;
      end
      default: ;
    endcase
    rd_addr = '0;
    if (rd_ok) rd_addr = cell_addr(phys_row(RW'(read_row), top_q), CW'(read_col));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      top_q       <= '0;
      blank_row_q <= '0;
      cnt_q       <= '0;
      clr_res_q   <= 1'b0;
      attr_q      <= AttrReset;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_cell_q  <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      if (cfg_we_i) attr_q <= cfg_wdata_i;

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cur_col_q  <= cur_col_d;
            cur_row_q  <= cur_row_d;
            out_col_q  <= CurColW'(cur_col_d);
            out_row_q  <= CurRowW'(cur_row_d);
            // a scrolling put keeps its cell here through the blank pass
            out_cell_q <= put_write ? put_cell : '0;
            out_scr_q  <= 1'b0;
            unique case (req)
              REQ_PUT: begin
                if (put_scroll) begin
                  // the old top row becomes the new bottom row
                  blank_row_q <= top_q;
                  top_q       <= (top_q == LastRow) ? '0 : top_q + 1'b1;
                  cnt_q       <= '0;
                  state_q     <= ST_BLANK;
                  out_valid_q <= 1'b0;
                end else begin
                  out_valid_q <= 1'b1;
                end
              end
              REQ_CLEAR: begin
                top_q       <= '0;
                cnt_q       <= '0;
                clr_res_q   <= 1'b1;
                state_q     <= ST_CLEAR;
                out_valid_q <= 1'b0;
              end
              REQ_READ: begin
                rd_ok_q     <= rd_ok;
                state_q     <= ST_READ;
                out_valid_q <= 1'b0;
              end
              default: out_valid_q <= 1'b1;
            endcase
          end else if (m_tready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_READ: begin
          out_cell_q  <= rd_ok_q ? rd_data_q : '0;
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_BLANK: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[CW-1:0] == LastCol) begin
            out_scr_q   <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastA) begin
            out_valid_q <= clr_res_q;
            clr_res_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0, out_scr_q, out_cell_q, out_row_q, out_col_q};

endmodule

FILE: sim/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: screen predictor and stream drivers.
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int ScreenCols = DefColumns;
  localparam int ScreenRows = DefRows;
  localparam int CellCount  = ScreenCols * ScreenRows;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 40;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 100;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [InDataW-42:0]  pad;
    logic [ReadRowW-1:0]  read_row;
    logic [ReadColW-1:0]  read_col;
    logic [TargetW-1:0]   target_row;
    logic [TargetW-1:0]   target_col;
    logic [CharW-1:0]     char_code;
  } request_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [OutDataW-29:0] pad;
    logic                 scrolled;
    logic [CellW-1:0]     cell_data;
    logic [CurRowW-1:0]   cursor_row;
    logic [CurColW-1:0]   cursor_col;
  } screen_result_t;

  class console_scoreboard;
    logic [CellW-1:0] screen [CellCount];
    int unsigned      col;
    int unsigned      row;
    logic [AttrW-1:0] attr;
    screen_result_t   pending_q[$];
    int               errors;

    function new();
      blank_screen();
      col    = 0;
      row    = 0;
      attr   = AttrReset;
      errors = 0;
    endfunction

    function void blank_screen();
      foreach (screen[i]) screen[i] = BlankCell;
    endfunction

    function void set_attr(logic [AttrW-1:0] value);
      attr = value;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    // Advance the screen model by one accepted item and queue its result.
    function void note_request(logic [ReqW-1:0] req, request_t f);
      screen_result_t r;
      int             tc;
      int             tr;
      r = '0;
      case (req)
        REQ_PUT: begin
          if (f.char_code != CharNul) begin
            if (f.char_code == CharCr || f.char_code == CharLf) begin
              col = 0;
              row++;
            end else begin
              r.cell_data = {attr, f.char_code};
              screen[row * ScreenCols + col] = r.cell_data;
              col++;
            end
            if (col > ScreenCols - 1) begin
              col = 0;
              row++;
            end
            if (row > ScreenRows - 1) begin
              row = ScreenRows - 1;
              col = 0;
              for (int i = 0; i < CellCount - ScreenCols; i++) screen[i] = screen[i + ScreenCols];
              for (int i = CellCount - ScreenCols; i < CellCount; i++) screen[i] = BlankCell;
              r.scrolled = 1'b1;
            end
          end
        end
        REQ_SET: begin
          tc  = $signed(f.target_col);
          tr  = $signed(f.target_row);
          col = (tc < 0) ? 0 : (tc > ScreenCols - 1) ? ScreenCols - 1 : tc;
          row = (tr < 0) ? 0 : (tr > ScreenRows - 1) ? ScreenRows - 1 : tr;
        end
        REQ_CLEAR: begin
          blank_screen();
          col = 0;
          row = 0;
        end
        REQ_BACK: begin
          if (col != 0) begin
            col--;
          end else if (row != 0) begin
            col = ScreenCols - 1;
            row--;
          end
        end
        REQ_READ: begin
          if (f.read_col < ScreenCols && f.read_row < ScreenRows)
            r.cell_data = screen[f.read_row * ScreenCols + f.read_col];
        end
        default: ;
      endcase
      r.cursor_col = col[CurColW-1:0];
      r.cursor_row = row[CurRowW-1:0];
      pending_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] tdata);
      screen_result_t got;
      screen_result_t want;
      got = tdata;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result 0x%h expected none actual arrived", $time, tdata);
        return;
      end
      want = pending_q.pop_front();
      compare_field("cursor_col", want.cursor_col, got.cursor_col);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("cell_data", want.cell_data, got.cell_data);
      compare_field("scrolled", want.scrolled, got.scrolled);
      compare_field("pad", 0, got.pad);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [AttrW-1:0]    cfg_wdata_i;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i;
  logic [ReqW-1:0]     s_tuser_i;
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [OutDataW-1:0] m_tdata_o;

  console_scoreboard board = new();
  int                cycle_count = 0;
  int                src_burst = 0;
  int                sink_burst = 0;

  text_console_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly random gaps, with occasional runs of back-to-back items.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic request_t make_fields(logic [CharW-1:0] ch, int tcol, int trow,
                                           int rcol, int rrow);
    request_t f;
    f            = '0;
    f.char_code  = ch;
    f.target_col = tcol[TargetW-1:0];
    f.target_row = trow[TargetW-1:0];
    f.read_col   = rcol[ReadColW-1:0];
    f.read_row   = rrow[ReadRowW-1:0];
    return f;
  endfunction

  // Entered and left at a falling edge; tvalid stays high on return.
  task automatic send_request(logic [ReqW-1:0] req, request_t f);
    int gap;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tuser_i  = req;
    s_tdata_i  = f;
    s_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    board.note_request(req, f);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_tvalid_i = 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap(sink_burst);
      if (stall > 0) begin
        m_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      board.check_result(m_tdata_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    request_t         f;
    logic [ReqW-1:0]  req;
    logic [63:0]      noise;
    logic [AttrW-1:0] attr;
    int               string_left;
    int               pick;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = '0;
    string_left = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corner cases, reset attribute
    send_request(REQ_SET, make_fields(8'h00, -1024, -1024, 0, 0));
    send_request(REQ_BACK, make_fields(8'h00, 0, 0, 0, 0));        // back at origin
    send_request(REQ_PUT, make_fields(8'h41, 0, 0, 0, 0));
    send_request(REQ_PUT, make_fields(CharNul, 0, 0, 0, 0));       // terminator
    send_request(REQ_PUT, make_fields(8'hff, 0, 0, 0, 0));
    send_request(REQ_PUT, make_fields(8'h80, 0, 0, 0, 0));
    send_request(REQ_READ, make_fields(8'h00, 0, 0, 0, 0));
    send_request(REQ_READ, make_fields(8'h00, 0, 0, ScreenCols - 1, ScreenRows - 1));
    send_request(REQ_PUT, make_fields(CharCr, 0, 0, 0, 0));
    send_request(REQ_PUT, make_fields(CharLf, 0, 0, 0, 0));
    send_request(REQ_SET, make_fields(8'h00, 0, 3, 0, 0));
    send_request(REQ_BACK, make_fields(8'h00, 0, 0, 0, 0));        // back onto previous row
    send_request(REQ_SET, make_fields(8'h00, 1023, 1023, 0, 0));
    send_request(REQ_PUT, make_fields(8'h7e, 0, 0, 0, 0));         // wrap plus scroll
    send_request(REQ_SET, make_fields(8'h00, -1, ScreenRows - 1, 0, 0));
    send_request(REQ_PUT, make_fields(CharLf, 0, 0, 0, 0));        // new line scroll
    send_request(REQ_READ, make_fields(8'h00, 0, 0, 0, ScreenRows - 3));
    send_request(REQ_READ, make_fields(8'h00, 0, 0, ScreenCols - 1, ScreenRows - 1));
    for (int k = REQ_READ + 1; k < (1 << ReqW); k++)
      send_request(k[ReqW-1:0], make_fields(8'hff, 1023, -1024, ScreenCols - 1, 0));
    send_request(REQ_SET, make_fields(8'h00, ScreenCols - 1, 0, 0, 0));
    send_request(REQ_PUT, make_fields(8'h5a, 0, 0, 0, 0));         // wrap, no scroll
    send_request(REQ_CLEAR, make_fields(8'h00, 0, 0, 0, 0));
    send_request(REQ_READ, make_fields(8'h00, 0, 0, 0, 0));

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1:       attr = '0;
          2:       attr = '1;
          default: attr = AttrW'($urandom_range(0, 255));
        endcase
        cfg_we_i    = 1'b1;
        cfg_wdata_i = attr;
        board.set_attr(attr);
        @(negedge clk_i);
        cfg_we_i = 1'b0;
      end
      repeat (PhaseItems) begin
        noise = {$urandom, $urandom};
        f     = noise[InDataW-1:0];
        f.pad = '0;
        if (string_left > 0) begin
          // text run: printable characters with the odd line break
          string_left--;
          req         = REQ_PUT;
          f.char_code = ($urandom_range(0, 11) == 0) ? CharLf : CharW'($urandom_range(32, 126));
        end else begin
          pick = $urandom_range(0, 199);
          if (pick == 0) begin
            req = REQ_CLEAR;
          end else if (pick <= 15) begin
            req         = REQ_PUT;
            string_left = $urandom_range(4, 70);
          end else if (pick <= 85) begin
            req = REQ_PUT;
            case ($urandom_range(0, 15))
              0:       f.char_code = CharCr;
              1:       f.char_code = CharLf;
              2:       f.char_code = CharNul;
              default: ;
            endcase
          end else if (pick <= 115) begin
            req = REQ_SET;
            case ($urandom_range(0, 3))
              0: ;   // full signed range, mostly clamped
              1: begin
                f.target_col = TargetW'($urandom_range(0, ScreenCols - 1));
                f.target_row = TargetW'($urandom_range(0, ScreenRows - 1));
              end
              2: begin
                f.target_col = TargetW'($urandom_range(ScreenCols - 16, ScreenCols - 1));
                f.target_row = TargetW'(ScreenRows - 1);
              end
              default: begin
                f.target_col = '0;
                f.target_row = TargetW'($urandom_range(ScreenRows - 4, ScreenRows - 1));
              end
            endcase
          end else if (pick <= 135) begin
            req = REQ_BACK;
          end else if (pick <= 185) begin
            req = REQ_READ;
          end else begin
            req = REQ_READ + ReqW'($urandom_range(1, 3));
          end
        end
        send_request(req, f);
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
